/* rtl/page_lcd_box_copy_assert.svh */
// Assertion macros used by the checker file.
`ifndef PAGE_LCD_BOX_COPY_ASSERT_SVH
`define PAGE_LCD_BOX_COPY_ASSERT_SVH

// Clocked check, quiet while reset is high.
`define PLBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked check that also covers the reset cycles.
`define PLBC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/plbc_pkg.sv */
package plbc_pkg;

  localparam int NUM_COLUMNS_DEF = 128;
  localparam int NUM_PAGES_DEF   = 8;

  // widest page index (16 pages) and column index (256 columns)
  localparam int PAGE_W      = 4;
  localparam int COL_W       = 8;
  localparam int ADDR_FULL_W = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CMD_PAGE      = 8'hb0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] COL_LOW_MASK  = 8'h0f;
  localparam int         ROWS_PER_PAGE = 8'h08;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CELL  = 1'b1;

  localparam logic [2:0] REG_SRC_COL    = 3'd0;
  localparam logic [2:0] REG_SRC_ROW    = 3'd1;
  localparam logic [2:0] REG_DST_COL    = 3'd2;
  localparam logic [2:0] REG_DST_ROW    = 3'd3;
  localparam logic [2:0] REG_BOX_WIDTH  = 3'd4;
  localparam logic [2:0] REG_BOX_HEIGHT = 3'd5;

  typedef enum logic {
    CMD_WRITE,
    CMD_CELL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [ADDR_FULL_W-1:0]  addr_dst;
    logic [ADDR_FULL_W-1:0]  addr_s0;
    logic [ADDR_FULL_W-1:0]  addr_s1;
    logic                    ok_s0;
    logic                    ok_s1;
    logic [2:0]              shift;
    logic [7:0]              mask;
    logic [7:0]              wdata;
    logic [PAGE_W-1:0]       pg;
    logic [COL_W-1:0]        col;
    logic                    done;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PAGE,
    BK_COLH,
    BK_COLL,
    BK_DATA
  } back_state_t;

  typedef enum logic [1:0] {
    RD_IDLE,
    RD_DST,
    RD_SRC0,
    RD_SRC1
  } rd_phase_t;

endpackage

/* rtl/plbc_front.sv */
module plbc_front #(
  parameter int NUM_COLUMNS = plbc_pkg::NUM_COLUMNS_DEF,
  parameter int NUM_PAGES   = plbc_pkg::NUM_PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                q_full,
  input  logic                req_type,
  input  logic [2:0]          page,
  input  logic [6:0]          column,
  input  logic [7:0]          data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output logic                q_push,
  output plbc_pkg::cmd_t      q_cmd
);

  localparam int AFW = plbc_pkg::ADDR_FULL_W;
  localparam int PW  = plbc_pkg::PAGE_W;

  function automatic logic [AFW-1:0] addr_of(input logic [PW-1:0] pg,
                                              input logic [7:0] cl);
    return AFW'(pg) * AFW'(NUM_COLUMNS) + AFW'(cl);
  endfunction

  logic [6:0] src_col, dst_col;
  logic [5:0] src_row, dst_row;
  logic [7:0] box_width;
  logic [6:0] box_height;
  logic [7:0] cursor_col, cursor_col_next;
  logic [PW-1:0] cursor_page, cursor_page_next;

  logic        accept, wr_ok, box_empty, cfg_hit;
  logic [8:0]  col_room, ncols;
  logic [2:0]  pstart;
  logic [7:0]  bottom;
  logic [4:0]  pend_true, pend, npages, x5, cp_inc;
  logic        wrap, scol_ok, sp0_ok, sp1_ok;
  logic [7:0]  cc, col;
  logic [8:0]  scol, cc_inc;
  logic [PW-1:0] cp, x;
  logic [2:0]  first, stop;
  logic signed [8:0] d;
  logic signed [5:0] sp0, sp1;
  logic        last_page, last_col;

  assign accept  = push && !q_full;
  assign cfg_hit = cfg_we && (cfg_index <= plbc_pkg::REG_BOX_HEIGHT);

  always_comb begin
    col_room  = 9'(NUM_COLUMNS) - {2'b0, dst_col};
    ncols     = ({1'b0, box_width} < col_room) ? {1'b0, box_width} : col_room;
    pstart    = dst_row[5:3];
    bottom    = {2'b0, dst_row} + {1'b0, box_height} - 8'd1;
    pend_true = bottom[7:3];
    pend      = (pend_true > 5'(NUM_PAGES - 1)) ? 5'(NUM_PAGES - 1) : pend_true;
    npages    = pend - {2'b0, pstart} + 5'd1;
    box_empty = (box_width == 8'd0) || (box_height == 7'd0) ||
                ({2'b0, dst_col} >= 9'(NUM_COLUMNS)) ||
                ({2'b0, pstart} >= 5'(NUM_PAGES));

    // restart from the first cell once the cursor falls outside the box
    wrap = ({1'b0, cursor_col} >= ncols) || ({1'b0, cursor_page} >= npages);
    cc   = wrap ? 8'd0 : cursor_col;
    cp   = wrap ? '0 : cursor_page;

    x5      = {2'b0, pstart} + {1'b0, cp};
    x       = x5[PW-1:0];
    col     = {1'b0, dst_col} + cc;
    scol    = {2'b0, src_col} + {1'b0, cc};
    scol_ok = scol < 9'(NUM_COLUMNS);

    first = (x5 == {2'b0, pstart}) ? dst_row[2:0] : 3'd0;
    stop  = (x5 == pend_true) ? bottom[2:0] : 3'd7;

    // source row of destination bit 0 of this page; may sit above row 0
    d   = $signed({3'b0, src_row}) + $signed({2'b0, x, 3'b0}) - $signed({3'b0, dst_row});
    sp0 = d[8:3];
    sp1 = sp0 + 6'sd1;
    sp0_ok = !sp0[5] && ({1'b0, sp0[4:0]} < 6'(NUM_PAGES)) && scol_ok;
    sp1_ok = !sp1[5] && ({1'b0, sp1[4:0]} < 6'(NUM_PAGES)) && scol_ok;

    cp_inc    = {1'b0, cp} + 5'd1;
    cc_inc    = {1'b0, cc} + 9'd1;
    last_page = cp_inc >= npages;
    last_col  = cc_inc >= ncols;

    wr_ok = ({2'b0, page} < 5'(NUM_PAGES)) && ({2'b0, column} < 9'(NUM_COLUMNS));

    q_cmd = '0;
    if (req_type == plbc_pkg::REQ_WRITE) begin
      q_cmd.kind     = plbc_pkg::CMD_WRITE;
      q_cmd.addr_dst = addr_of(PW'(page), {1'b0, column});
      q_cmd.wdata    = data;
      q_push         = accept && wr_ok;
    end else begin
      q_cmd.kind     = plbc_pkg::CMD_CELL;
      q_cmd.addr_dst = addr_of(x, col);
      q_cmd.addr_s0  = sp0_ok ? addr_of(sp0[PW-1:0], scol[7:0]) : '0;
      q_cmd.addr_s1  = sp1_ok ? addr_of(sp1[PW-1:0], scol[7:0]) : '0;
      q_cmd.ok_s0    = sp0_ok;
      q_cmd.ok_s1    = sp1_ok;
      q_cmd.shift    = d[2:0];
      q_cmd.mask     = (8'hff << first) & (8'hff >> (3'd7 - stop));
      q_cmd.pg       = x;
      q_cmd.col      = col;
      q_cmd.done     = last_page && last_col;
      q_push         = accept && !box_empty;
    end

    cursor_col_next  = cursor_col;
    cursor_page_next = cursor_page;
    if (cfg_hit) begin
      cursor_col_next  = '0;
      cursor_page_next = '0;
    end else if (accept && req_type == plbc_pkg::REQ_CELL && !box_empty) begin
      if (last_page) begin
        cursor_page_next = '0;
        cursor_col_next  = last_col ? 8'd0 : cc_inc[7:0];
      end else begin
        cursor_page_next = cp_inc[PW-1:0];
        cursor_col_next  = cc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col     <= '0;
      src_row     <= '0;
      dst_col     <= '0;
      dst_row     <= '0;
      box_width   <= 8'd1;
      box_height  <= 7'd1;
      cursor_col  <= '0;
      cursor_page <= '0;
    end else begin
      cursor_col  <= cursor_col_next;
      cursor_page <= cursor_page_next;
      if (cfg_we) begin
        unique case (cfg_index)
          plbc_pkg::REG_SRC_COL:    src_col    <= cfg_data[6:0];
          plbc_pkg::REG_SRC_ROW:    src_row    <= cfg_data[5:0];
          plbc_pkg::REG_DST_COL:    dst_col    <= cfg_data[6:0];
          plbc_pkg::REG_DST_ROW:    dst_row    <= cfg_data[5:0];
          plbc_pkg::REG_BOX_WIDTH:  box_width  <= cfg_data;
          plbc_pkg::REG_BOX_HEIGHT: box_height <= cfg_data[6:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* rtl/plbc_queue.sv */
module plbc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_en,
  input  plbc_pkg::cmd_t cmd_in,
  input  logic           pop_en,
  output logic           full,
  output logic           empty,
  output plbc_pkg::cmd_t cmd_out
);

  localparam int DEPTH = plbc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  plbc_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push, do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push_en && !full;
  assign do_pop  = pop_en && !empty;
  assign cmd_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

endmodule

/* rtl/plbc_back.sv */
module plbc_back #(
  parameter int NUM_COLUMNS = plbc_pkg::NUM_COLUMNS_DEF,
  parameter int NUM_PAGES   = plbc_pkg::NUM_PAGES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  plbc_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     lcd_byte,
  output logic           is_data,
  output logic           last,
  output logic           copy_done
);

  localparam int DEPTH  = NUM_PAGES * NUM_COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int AFW    = plbc_pkg::ADDR_FULL_W;

  logic [7:0] mem [DEPTH];

  plbc_pkg::back_state_t state, state_next;
  plbc_pkg::rd_phase_t   rd_phase;
  plbc_pkg::cmd_t        cur;

  logic        out_valid, pop_out, slot_free, emit;
  logic [7:0]  word_byte, rdata, orig, s0, s1, pix, result;
  logic [15:0] pix_wide;
  logic        word_data, word_done;
  logic [AFW-1:0] rd_addr;

  assign empty     = !out_valid;
  assign pop_out   = pop && out_valid;
  assign slot_free = !out_valid || pop_out;

  always_comb begin
    pix_wide = {s1, s0} >> cur.shift;
    pix      = pix_wide[7:0];
    result   = (orig & ~cur.mask) | (pix & cur.mask);
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit       = 1'b0;
    word_byte  = '0;
    word_data  = 1'b0;
    word_done  = 1'b0;
    unique case (state)
      plbc_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = (q_cmd.kind == plbc_pkg::CMD_CELL) ? plbc_pkg::BK_PAGE
                                                           : plbc_pkg::BK_IDLE;
        end
      end
      plbc_pkg::BK_PAGE: begin
        word_byte = plbc_pkg::CMD_PAGE | {4'b0, cur.pg};
        if (slot_free) begin
          emit       = 1'b1;
          state_next = plbc_pkg::BK_COLH;
        end
      end
      plbc_pkg::BK_COLH: begin
        word_byte = plbc_pkg::CMD_COL_HIGH | {4'b0, cur.col[7:4]};
        if (slot_free) begin
          emit       = 1'b1;
          state_next = plbc_pkg::BK_COLL;
        end
      end
      plbc_pkg::BK_COLL: begin
        word_byte = cur.col & plbc_pkg::COL_LOW_MASK;
        if (slot_free) begin
          emit       = 1'b1;
          state_next = plbc_pkg::BK_DATA;
        end
      end
      plbc_pkg::BK_DATA: begin
        word_byte = result;
        word_data = 1'b1;
        word_done = cur.done;
        if (slot_free && rd_phase == plbc_pkg::RD_IDLE) begin
          emit = 1'b1;
          // take the next command in the same cycle as the pixel word
          if (!q_empty) begin
            q_pop      = 1'b1;
            state_next = (q_cmd.kind == plbc_pkg::CMD_CELL) ? plbc_pkg::BK_PAGE
                                                             : plbc_pkg::BK_IDLE;
          end else begin
            state_next = plbc_pkg::BK_IDLE;
          end
        end
      end
      default: state_next = plbc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    unique case (rd_phase)
      plbc_pkg::RD_DST:  rd_addr = cur.addr_s0;
      plbc_pkg::RD_SRC0: rd_addr = cur.addr_s1;
      default:           rd_addr = q_cmd.addr_dst;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plbc_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_phase  <= plbc_pkg::RD_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (q_pop && q_cmd.kind == plbc_pkg::CMD_CELL) begin
        rd_phase <= plbc_pkg::RD_DST;
      end else begin
        unique case (rd_phase)
          plbc_pkg::RD_DST:  rd_phase <= plbc_pkg::RD_SRC0;
          plbc_pkg::RD_SRC0: rd_phase <= plbc_pkg::RD_SRC1;
          default:           rd_phase <= plbc_pkg::RD_IDLE;
        endcase
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop_out) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.kind == plbc_pkg::CMD_WRITE) begin
      mem[q_cmd.addr_dst[ADDR_W-1:0]] <= q_cmd.wdata;
    end
    rdata <= mem[rd_addr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.kind == plbc_pkg::CMD_CELL) begin
      cur <= q_cmd;
    end
    unique case (rd_phase)
      plbc_pkg::RD_DST:  orig <= rdata;
      plbc_pkg::RD_SRC0: s0   <= cur.ok_s0 ? rdata : 8'd0;
      plbc_pkg::RD_SRC1: s1   <= cur.ok_s1 ? rdata : 8'd0;
      default: ;
    endcase
    if (emit) begin
      lcd_byte  <= word_byte;
      is_data   <= word_data;
      last      <= word_data;
      copy_done <= word_done;
    end
  end

endmodule

/* rtl/page_lcd_box_copy.sv */
// Box copy for a page-organised monochrome display, one bit per pixel.
// Input channel (push/full): req_type 0 stores data at (page, column) in the
// frame store; req_type 1 emits the next destination cell of the box. A cell
// gives four words on the result channel (empty/pop): page command, high
// column command, low column command, pixel byte with last set. copy_done
// marks the pixel byte of the final visible cell.
// Configuration (cfg_we, cfg_index, cfg_data) sets source/destination corners
// and box size; a write to any of the six restarts the copy at the first cell.
// Each cell steps through the page, high column, low column and pixel states;
// the single result register takes one word a cycle while pop is held high,
// and the three frame-store reads for a cell share the one read port. The
// command queue takes new items while the back end works on a cell.
// A write item is stored when the back end takes it from the queue.
// Reset clears configuration to defaults, the cursor, the command queue and
// the result register; the frame store holds nothing until written.
// When pop stays low the result word holds, the back end stops, the two-entry
// command queue fills and full rises.
module page_lcd_box_copy #(
  parameter int NUM_COLUMNS = plbc_pkg::NUM_COLUMNS_DEF,
  parameter int NUM_PAGES   = plbc_pkg::NUM_PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       req_type,
  input  logic [2:0] page,
  input  logic [6:0] column,
  input  logic [7:0] data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] lcd_byte,
  output logic       is_data,
  output logic       last,
  output logic       copy_done
);

  plbc_pkg::cmd_t f_cmd, q_cmd;
  logic f_push, q_empty, q_pop;

  plbc_front #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_PAGES   (NUM_PAGES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .q_full    (full),
    .req_type  (req_type),
    .page      (page),
    .column    (column),
    .data      (data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (f_push),
    .q_cmd     (f_cmd)
  );

  plbc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_en (f_push),
    .cmd_in  (f_cmd),
    .pop_en  (q_pop),
    .full    (full),
    .empty   (q_empty),
    .cmd_out (q_cmd)
  );

  plbc_back #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_PAGES   (NUM_PAGES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .lcd_byte  (lcd_byte),
    .is_data   (is_data),
    .last      (last),
    .copy_done (copy_done)
  );

endmodule

/* rtl/plbc_checker.sv */
`include "page_lcd_box_copy_assert.svh"

module plbc_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] lcd_byte,
  input logic       is_data,
  input logic       last,
  input logic       copy_done
);

  `PLBC_ASSERT_RST(a_reset_empty, rst |=> empty, "result word present after reset")

  // hold the waiting word while the receiver stalls
  `PLBC_ASSERT(a_hold_word, !empty && !pop |=> !empty && $stable(lcd_byte) && $stable(is_data), "stalled word changed")

  `PLBC_ASSERT(a_done_on_pixel, !empty && copy_done |-> is_data && last, "copy_done off the pixel byte")

  `PLBC_ASSERT(a_last_is_pixel, !empty |-> is_data == last, "last and is_data disagree")

endmodule

bind page_lcd_box_copy plbc_checker u_plbc_checker (.*);
